FILE: src/hcv_pkg.sv
package hcv_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int BYTE_W  = 8;
  localparam int CRC_W   = 16;
  localparam int LEN_W   = 24;
  localparam int MAGIC_W = 32;
  localparam int VER_W   = 8;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 72;

  localparam logic [CRC_W-1:0] CRC_INIT   = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY   = 16'hA001;
  localparam logic [CRC_W-1:0] CRC_XOROUT = 16'hFFFF;

  localparam int MIN_IMAGE   = 12;
  localparam int BODY_START  = 8;
  localparam int MAGIC_BYTES = 4;
  localparam int VERSION_POS = 4;
  localparam int CRC_LO_POS  = 6;
  localparam int CRC_HI_POS  = 7;

  localparam logic [MAGIC_W-1:0] MAGIC_RESET   = 32'h4E4D4749;
  localparam logic [VER_W-1:0]   VERSION_RESET = 8'h00;
  localparam logic [LEN_W-1:0]   MAX_LEN_RESET = 24'd65536;

  typedef enum logic [2:0] {
    REASON_OK       = 3'd0,
    REASON_READ_ERR = 3'd1,
    REASON_SHORT    = 3'd2,
    REASON_LONG     = 3'd3,
    REASON_MAGIC    = 3'd4,
    REASON_VERSION  = 3'd5,
    REASON_CRC      = 3'd6
  } reason_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC   = 2'd0,
    CFG_VERSION = 2'd1,
    CFG_MAX_LEN = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              last_item;
    logic              read_error;
  } item_t;

  typedef struct packed {
    logic [MAGIC_W-1:0] magic_word;
    logic [VER_W-1:0]   version_byte;
    logic [CRC_W-1:0]   header_crc;
    logic [CRC_W-1:0]   crc_register;
    logic               overlong_flag;
  } hdr_state_t;

  localparam hdr_state_t HDR_RESET = '{
    magic_word:    '0,
    version_byte:  8'hFF,
    header_crc:    16'hFFFF,
    crc_register:  CRC_INIT,
    overlong_flag: 1'b0
  };

  typedef struct packed {
    logic [MAGIC_W-1:0] expected_magic;
    logic [VER_W-1:0]   expected_version;
    logic [LEN_W-1:0]   max_length;
  } cfg_t;

  // first member sits in the top bits, so accepted ends up in bit 0
  typedef struct packed {
    logic [CRC_W-1:0] crc_stored;
    logic [CRC_W-1:0] crc_computed;
    logic [VER_W-1:0] version_seen;
    logic [LEN_W-1:0] byte_total;
    reason_t          reject_reason;
    logic             accepted;
  } result_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: src/image_header_crc_validator_top.sv
// Image header validator. Bytes stream in one per transfer on the slave side
// (tuser[0] says the transfer carries a byte, tuser[1] flags a read error,
// tlast ends the image); a single verdict comes out on the master side for
// each image, on its last transfer or on a read error. One transfer is taken
// every cycle unless a closing transfer waits on an earlier verdict still
// held for m_tready. The closing transfer is registered in the input stage
// and its verdict in the result register. The per-stream state loop (crc-16
// byte step, saturating byte counter, header capture) sets that rate.
// Configuration is to be written only between images; no check enforces it.
module image_header_crc_validator_top
  import hcv_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // data_byte[7:0]
  input  logic [IN_USER_W-1:0]  s_tuser,   // has_byte, read_error
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // accepted, reject_reason[2:0], byte_total[23:0], version_seen[7:0],
  // crc_computed[15:0], crc_stored[15:0], zero padding
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  cfg_t                   cfg;
  logic                   in_valid;
  item_t                  in_item;
  logic                   emit;
  logic                   advance;
  logic [COUNT_WIDTH-1:0] cnt_after;
  hdr_state_t             hdr_after;
  result_t                verdict;
  result_t                out_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_magic   <= MAGIC_RESET;
      cfg.expected_version <= VERSION_RESET;
      cfg.max_length       <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MAGIC:   cfg.expected_magic   <= cfg_data[MAGIC_W-1:0];
        CFG_VERSION: cfg.expected_version <= cfg_data[VER_W-1:0];
        CFG_MAX_LEN: cfg.max_length       <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // item needs the result register only when it closes a stream
  assign emit     = in_item.last_item || in_item.read_error;
  assign advance  = in_valid && (!emit || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.data_byte  <= s_tdata;
      in_item.has_byte   <= s_tuser[0];
      in_item.read_error <= s_tuser[1];
      in_item.last_item  <= s_tlast;
    end
  end

  hcv_track #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_track (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .item       (in_item),
    .max_length (cfg.max_length),
    .cnt_after  (cnt_after),
    .hdr_after  (hdr_after)
  );

  hcv_judge #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_judge (
    .cnt        (cnt_after),
    .hdr        (hdr_after),
    .read_error (in_item.read_error),
    .cfg        (cfg),
    .result     (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_result <= verdict;
    end
  end

  assign m_tdata = {(OUT_DATA_W - $bits(result_t))'(0), out_result};

`ifndef SYNTH
  a_accept_matches_reason: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_result.accepted == (out_result.reject_reason == REASON_OK)))
    else $error("accepted flag disagrees with reject reason");

  a_reason_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_result.reject_reason != 3'd7))
    else $error("reject reason out of range");

  a_no_version_when_short: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_result.reject_reason == REASON_SHORT)
     && (out_result.byte_total < LEN_W'(VERSION_POS + 1)))
    |-> (out_result.version_seen == 8'hFF))
    else $error("version reported for an image without a version byte");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !m_tvalid && !in_valid)
    else $error("result or input stage valid after reset");
`endif

endmodule

FILE: src/hcv_track.sv
module hcv_track
  import hcv_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  item_t                  item,
  input  logic [LEN_W-1:0]       max_length,
  output logic [COUNT_WIDTH-1:0] cnt_after,
  output hdr_state_t             hdr_after
);

  localparam int CMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;

  logic [COUNT_WIDTH-1:0] byte_counter;
  hdr_state_t             hdr;
  logic                   take;
  logic [CMP_W-1:0]       cnt_ext;
  logic [CMP_W-1:0]       max_ext;

  assign take    = item.has_byte && !item.read_error;
  assign cnt_ext = CMP_W'(cnt_after);
  assign max_ext = CMP_W'(max_length);

  always_comb begin
    cnt_after = byte_counter;
    hdr_after = hdr;
    if (take) begin
      if (byte_counter < COUNT_WIDTH'(MAGIC_BYTES)) begin
        for (int i = 0; i < MAGIC_BYTES; i++) begin
          if (byte_counter[1:0] == 2'(i)) begin
            hdr_after.magic_word[BYTE_W*i +: BYTE_W] = item.data_byte;
          end
        end
      end else if (byte_counter == COUNT_WIDTH'(VERSION_POS)) begin
        hdr_after.version_byte = item.data_byte;
      end else if (byte_counter == COUNT_WIDTH'(CRC_LO_POS)) begin
        hdr_after.header_crc[BYTE_W-1:0] = item.data_byte;
      end else if (byte_counter == COUNT_WIDTH'(CRC_HI_POS)) begin
        hdr_after.header_crc[CRC_W-1:BYTE_W] = item.data_byte;
      end
      if (byte_counter >= COUNT_WIDTH'(BODY_START)) begin
        hdr_after.crc_register = crc_byte(hdr.crc_register, item.data_byte);
      end
      // saturating count
      if (byte_counter != '1) begin
        cnt_after = byte_counter + 1'b1;
      end
      if (cnt_ext > max_ext) begin
        hdr_after.overlong_flag = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_counter <= '0;
      hdr          <= HDR_RESET;
    end else if (step) begin
      if (item.last_item || item.read_error) begin
        byte_counter <= '0;
        hdr          <= HDR_RESET;
      end else begin
        byte_counter <= cnt_after;
        hdr          <= hdr_after;
      end
    end
  end

endmodule

FILE: src/hcv_judge.sv
module hcv_judge
  import hcv_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic [COUNT_WIDTH-1:0] cnt,
  input  hdr_state_t             hdr,
  input  logic                   read_error,
  input  cfg_t                   cfg,
  output result_t                result
);

  localparam int CMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;

  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] max_ext;
  logic [CRC_W-1:0] final_crc;
  reason_t          reason;

  assign cnt_ext   = CMP_W'(cnt);
  assign max_ext   = CMP_W'(cfg.max_length);
  assign final_crc = hdr.crc_register ^ CRC_XOROUT;

  // checks in priority order, lowest code wins
  always_comb begin
    if (read_error) begin
      reason = REASON_READ_ERR;
    end else if (cnt_ext < CMP_W'(MIN_IMAGE)) begin
      reason = REASON_SHORT;
    end else if (hdr.overlong_flag || (cnt_ext > max_ext)) begin
      reason = REASON_LONG;
    end else if (hdr.magic_word != cfg.expected_magic) begin
      reason = REASON_MAGIC;
    end else if (hdr.version_byte != cfg.expected_version) begin
      reason = REASON_VERSION;
    end else if (final_crc != hdr.header_crc) begin
      reason = REASON_CRC;
    end else begin
      reason = REASON_OK;
    end
  end

  always_comb begin
    result.accepted      = (reason == REASON_OK);
    result.reject_reason = reason;
    result.byte_total    = cnt_ext[LEN_W-1:0];
    result.version_seen  = hdr.version_byte;
    result.crc_computed  = final_crc;
    result.crc_stored    = hdr.header_crc;
  end

endmodule

FILE: tb/image_header_crc_validator_top_test.sv
`timescale 1ns / 1ps

module image_header_crc_validator_top_test;
  import hcv_pkg::*;

  typedef enum {
    CLEAN, BAD_MAGIC, BAD_VERSION, BAD_CRC_FIELD, BAD_BODY, ABORTED, GARBAGE
  } image_fault_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic [IN_USER_W-1:0] s_tuser;
  logic s_tlast;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // no random idling on either side while set
  logic steady = 1'b0;
  int unsigned items_sent = 0;
  int unsigned mismatch_count = 0;

  // register copies
  logic [MAGIC_W-1:0] exp_magic;
  logic [VER_W-1:0] exp_version;
  logic [LEN_W-1:0] max_len;

  // per-image tracking
  logic [LEN_W-1:0] len_count;
  logic [CRC_W-1:0] crc_acc;
  logic [MAGIC_W-1:0] magic_cap;
  logic [VER_W-1:0] ver_cap;
  logic [CRC_W-1:0] crc_hdr;
  logic too_long;

  result_t verdict_q[$];

  image_header_crc_validator_top u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // bit-serial form of the reflected crc-16
  function automatic logic [CRC_W-1:0] crc16_step(logic [CRC_W-1:0] acc, logic [7:0] b);
    logic [CRC_W-1:0] r;
    logic fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = {1'b0, r[CRC_W-1:1]} ^ (fb ? CRC_POLY : '0);
    end
    return r;
  endfunction

  function automatic void clear_image_state();
    len_count = '0;
    crc_acc = CRC_INIT;
    magic_cap = '0;
    ver_cap = 8'hFF;
    crc_hdr = 16'hFFFF;
    too_long = 1'b0;
  endfunction

  function automatic void predict_verdict(logic [7:0] b, logic has, logic last, logic err);
    result_t v;
    reason_t reason;
    logic [CRC_W-1:0] final_crc;
    if (!err && has) begin
      if (len_count < MAGIC_BYTES) magic_cap[8*len_count[1:0] +: 8] = b;
      else if (len_count == VERSION_POS) ver_cap = b;
      else if (len_count == CRC_LO_POS) crc_hdr[7:0] = b;
      else if (len_count == CRC_HI_POS) crc_hdr[15:8] = b;
      if (len_count >= BODY_START) crc_acc = crc16_step(crc_acc, b);
      if (len_count != '1) len_count++;
      if (len_count > max_len) too_long = 1'b1;
    end
    if (!err && !last) return;
    final_crc = crc_acc ^ CRC_XOROUT;
    if (err) reason = REASON_READ_ERR;
    else if (len_count < MIN_IMAGE) reason = REASON_SHORT;
    else if (too_long || len_count > max_len) reason = REASON_LONG;
    else if (magic_cap != exp_magic) reason = REASON_MAGIC;
    else if (ver_cap != exp_version) reason = REASON_VERSION;
    else if (final_crc != crc_hdr) reason = REASON_CRC;
    else reason = REASON_OK;
    v.accepted = (reason == REASON_OK);
    v.reject_reason = reason;
    v.byte_total = len_count;
    v.version_seen = ver_cap;
    v.crc_computed = final_crc;
    v.crc_stored = crc_hdr;
    verdict_q.push_back(v);
    clear_image_state();
  endfunction

  task automatic send_item(logic [7:0] b, logic has, logic last, logic err);
    while (!steady && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= {err, has};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_verdict(b, has, last, err);
    if (has || last || err) items_sent++;
  endtask

  task automatic send_image(int unsigned len, image_fault_t fault);
    logic [7:0] img[$];
    logic [CRC_W-1:0] body_crc;
    int unsigned cut;
    int unsigned k;
    logic split_end;
    img = {};
    if (fault == GARBAGE) begin
      repeat (len) img.push_back(8'($urandom));
    end else begin
      for (int i = 0; i < MAGIC_BYTES; i++) img.push_back(exp_magic[8*i +: 8]);
      img.push_back(exp_version);
      img.push_back(8'($urandom));
      img.push_back(8'h00);
      img.push_back(8'h00);
      for (int i = BODY_START; i < len; i++) img.push_back(8'($urandom));
      body_crc = CRC_INIT;
      for (int i = BODY_START; i < len; i++) body_crc = crc16_step(body_crc, img[i]);
      body_crc = body_crc ^ CRC_XOROUT;
      img[CRC_LO_POS] = body_crc[7:0];
      img[CRC_HI_POS] = body_crc[15:8];
      case (fault)
        BAD_MAGIC: begin
          k = $urandom_range(MAGIC_BYTES - 1);
          img[k] = img[k] ^ 8'($urandom_range(1, 255));
        end
        BAD_VERSION: img[VERSION_POS] = img[VERSION_POS] ^ 8'($urandom_range(1, 255));
        BAD_CRC_FIELD: begin
          k = $urandom_range(CRC_LO_POS, CRC_HI_POS);
          img[k] = img[k] ^ 8'($urandom_range(1, 255));
        end
        BAD_BODY: begin
          k = (img.size() > BODY_START) ? $urandom_range(BODY_START, img.size() - 1) : CRC_LO_POS;
          img[k] = img[k] ^ 8'($urandom_range(1, 255));
        end
        default: ;
      endcase
    end
    cut = (fault == ABORTED) ? $urandom_range(0, img.size() - 1) : img.size();
    split_end = ($urandom_range(3) == 0) || (img.size() == 0);
    for (int i = 0; i < img.size(); i++) begin
      // idle transfer with no byte and no end mark
      if ($urandom_range(19) == 0) send_item(8'($urandom), 1'b0, 1'b0, 1'b0);
      if (i == cut) begin
        send_item(img[i], 1'($urandom), 1'($urandom), 1'b1);
        return;
      end
      send_item(img[i], 1'b1, (i == img.size() - 1) && !split_end, 1'b0);
    end
    if (split_end) send_item(8'($urandom), 1'b0, 1'b1, 1'b0);
  endtask

  task automatic random_images(int unsigned budget, int unsigned longest);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    image_fault_t fault;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) fault = CLEAN;
      else if (pick < 63) fault = BAD_MAGIC;
      else if (pick < 70) fault = BAD_VERSION;
      else if (pick < 78) fault = BAD_CRC_FIELD;
      else if (pick < 84) fault = BAD_BODY;
      else if (pick < 92) fault = ABORTED;
      else fault = GARBAGE;
      if (fault == GARBAGE) len = $urandom_range(0, longest);
      else if ($urandom_range(9) == 0) len = $urandom_range(BODY_START, MIN_IMAGE - 1);
      else len = $urandom_range(MIN_IMAGE, longest);
      send_image(len, fault);
    end
  endtask

  // block may still be busy after the last verdict, so let it settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(logic [MAGIC_W-1:0] magic, logic [VER_W-1:0] ver,
                           logic [LEN_W-1:0] limit);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAGIC;
    cfg_data <= magic;
    @(posedge clk);
    cfg_index <= CFG_VERSION;
    cfg_data <= {{(CFG_W-VER_W){1'b0}}, ver};
    @(posedge clk);
    cfg_index <= CFG_MAX_LEN;
    cfg_data <= {{(CFG_W-LEN_W){1'b0}}, limit};
    @(posedge clk);
    cfg_we <= 1'b0;
    exp_magic = magic;
    exp_version = ver;
    max_len = limit;
    @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : verdict_monitor
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (verdict_q.size() == 0) begin
        $error("verdict transfer with no image closed");
        mismatch_count++;
      end else begin
        want = verdict_q.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(got.accepted));
        check_field("reject_reason", 32'(want.reject_reason), 32'(got.reject_reason));
        check_field("byte_total", 32'(want.byte_total), 32'(got.byte_total));
        check_field("version_seen", 32'(want.version_seen), 32'(got.version_seen));
        check_field("crc_computed", 32'(want.crc_computed), 32'(got.crc_computed));
        check_field("crc_stored", 32'(want.crc_stored), 32'(got.crc_stored));
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 10);
  end

  task automatic test_directed_cases();
    send_image(MIN_IMAGE, CLEAN);
    // read error together with end mark and a byte
    send_item(8'hFF, 1'b1, 1'b1, 1'b1);
    // empty end item on an empty stream
    send_item(8'h00, 1'b0, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic test_reset_config();
    random_images(150, 40);
    wait_idle();
  endtask

  task automatic test_min_length_limit();
    configure(32'($urandom), 8'hFF, 24'(MIN_IMAGE));
    send_image(MIN_IMAGE, CLEAN);
    send_image(MIN_IMAGE + 1, CLEAN);
    random_images(150, MIN_IMAGE + 2);
    wait_idle();
  endtask

  task automatic test_max_length_limit();
    configure(32'hFFFF_FFFF, 8'($urandom), 24'hFF_FFFF);
    steady = 1'b1;
    random_images(150, 48);
    wait_idle();
    steady = 1'b0;
  endtask

  task automatic test_small_limit();
    int unsigned limit;
    limit = $urandom_range(MIN_IMAGE, 40);
    configure(32'h0000_0000, 8'h00, 24'(limit));
    send_image(limit, CLEAN);
    send_image(limit + 1, CLEAN);
    random_images(150, limit + 4);
    wait_idle();
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    s_tlast <= 1'b0;
    m_tready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_MAGIC;
    cfg_data <= '0;
    exp_magic = MAGIC_RESET;
    exp_version = VERSION_RESET;
    max_len = MAX_LEN_RESET;
    clear_image_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_reset_config();
    test_min_length_limit();
    test_max_length_limit();
    test_small_limit();

    for (int n = 0; n < 1000 && verdict_q.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $error("%0d verdicts never arrived", verdict_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
